/* design/pfp_pkg.sv */
package pfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int VALUE_BYTES = 4;
    localparam int BUF_BYTES   = 4;
    localparam int CFG_INDEX_W = 8;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hFE;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hFC;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 8'd1;

    // event kinds
    localparam logic EVT_RECORD = 1'b0;
    localparam logic EVT_FRAME  = 1'b1;

    typedef struct packed {
        logic               event_kind;
        logic [WORD_W-1:0]  record_name;
        logic [WORD_W-1:0]  record_value;
        logic [COUNT_W-1:0] frame_count;
        logic               last_record;
    } t_result;

endpackage

/* design/pfp_if.sv */
interface pfp_in_if;
    logic                         valid;
    logic                         ready;
    logic [pfp_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfp_out_if;
    logic                         valid;
    logic                         ready;
    logic                         event_kind;
    logic [pfp_pkg::WORD_W-1:0]   record_name;
    logic [pfp_pkg::WORD_W-1:0]   record_value;
    logic [pfp_pkg::COUNT_W-1:0]  frame_count;
    logic                         last_record;

    modport source (output valid, output event_kind, output record_name,
                    output record_value, output frame_count, output last_record,
                    input ready);
    modport sink   (input valid, input event_kind, input record_name,
                    input record_value, input frame_count, input last_record,
                    output ready);
endinterface

interface pfp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pfp_pkg::CFG_INDEX_W-1:0]  index;
    logic [pfp_pkg::BYTE_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/pfp_core.sv */
module pfp_core #(
    parameter int NAME_BYTES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [pfp_pkg::BYTE_W-1:0]  i_byte,
    input  logic [pfp_pkg::BYTE_W-1:0]  i_hdr_first,
    input  logic [pfp_pkg::BYTE_W-1:0]  i_hdr_second,
    output logic                        o_res_valid,
    output pfp_pkg::t_result            o_res
);

    localparam int SLOT_MAX = (NAME_BYTES > pfp_pkg::VALUE_BYTES) ?
                              NAME_BYTES : pfp_pkg::VALUE_BYTES;
    localparam int IDX_W    = $clog2(SLOT_MAX);
    localparam logic [IDX_W-1:0] NAME_LAST  = IDX_W'(NAME_BYTES - 1);
    localparam logic [IDX_W-1:0] VALUE_LAST = IDX_W'(pfp_pkg::VALUE_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_COUNT,
        PH_NAME,
        PH_VALUE
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [IDX_W-1:0]               r_idx, n_idx;
    logic [pfp_pkg::COUNT_W-1:0]    r_records, n_records;
    logic [pfp_pkg::WORD_W-1:0]     r_name, n_name;
    logic [pfp_pkg::WORD_W-1:0]     r_value, n_value;
    logic [pfp_pkg::BYTE_W-1:0]     hdr_want;

    assign hdr_want = (r_idx == '0) ? i_hdr_first : i_hdr_second;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_records   = r_records;
        n_name      = r_name;
        n_value     = r_value;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_step) begin
            unique case (r_phase)
                PH_HEAD: begin
                    // drop a mismatching byte and restart the header hunt
                    if (i_byte == hdr_want) begin
                        if (r_idx == '0) begin
                            n_idx = IDX_ONE;
                        end else begin
                            n_phase = PH_COUNT;
                            n_idx   = '0;
                        end
                    end else begin
                        n_idx = '0;
                    end
                end
                PH_COUNT: begin
                    o_res_valid       = 1'b1;
                    o_res.event_kind  = pfp_pkg::EVT_FRAME;
                    o_res.frame_count = i_byte;
                    n_idx             = '0;
                    if (i_byte == '0) begin
                        n_phase   = PH_HEAD;
                        n_records = '0;
                    end else begin
                        n_phase   = PH_NAME;
                        n_records = i_byte;
                        n_name    = '0;
                    end
                end
                PH_NAME: begin
                    // name bytes past the buffer width are consumed and dropped
                    if (int'(r_idx) < pfp_pkg::BUF_BYTES) begin
                        n_name[8*r_idx[1:0] +: 8] = i_byte;
                    end
                    if (r_idx == NAME_LAST) begin
                        n_phase = PH_VALUE;
                        n_idx   = '0;
                        n_value = '0;
                    end else begin
                        n_idx = r_idx + IDX_ONE;
                    end
                end
                PH_VALUE: begin
                    n_value[8*r_idx[1:0] +: 8] = i_byte;
                    if (r_idx == VALUE_LAST) begin
                        o_res_valid        = 1'b1;
                        o_res.event_kind   = pfp_pkg::EVT_RECORD;
                        o_res.record_name  = r_name;
                        o_res.record_value = n_value;
                        o_res.last_record  = (r_records == pfp_pkg::COUNT_W'(1));
                        n_records          = r_records - pfp_pkg::COUNT_W'(1);
                        n_idx              = '0;
                        if (r_records == pfp_pkg::COUNT_W'(1)) begin
                            n_phase = PH_HEAD;
                        end else begin
                            n_phase = PH_NAME;
                            n_name  = '0;
                        end
                    end else begin
                        n_idx = r_idx + IDX_ONE;
                    end
                end
                default: begin
                    n_phase = PH_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEAD;
            r_idx     <= '0;
            r_records <= '0;
        end else begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_records <= n_records;
        end
        r_name  <= n_name;
        r_value <= n_value;
    end

    a_head_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEAD |-> r_idx <= IDX_ONE)
        else $error("header position out of range");

    a_records_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NAME || r_phase == PH_VALUE) |-> r_records != '0)
        else $error("record phase with no records left");

    a_count_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_COUNT) |=>
            ((r_phase == PH_HEAD && r_records == '0) ||
             (r_phase == PH_NAME && r_records == $past(i_byte))))
        else $error("count byte not loaded");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last_record) |=> r_phase == PH_HEAD)
        else $error("last record did not end the frame");

endmodule

/* design/param_frame_parser_top.sv */
// Parameter frame parser.
// Channels: i_rx takes one received serial byte per request; o_evt delivers
// events; i_cfg writes the two header bytes (index 0 first, index 1 second),
// always ready, and must only be used while the parser is idle.
// Each frame is a two-byte header, a count byte and that many records of
// NAME_BYTES name bytes plus four little-endian value bytes. The count byte
// yields a frame event (a zero count is a heartbeat); the last value byte
// of each record yields a record event, flagged when it ends the frame.
// A header mismatch drops the byte and restarts the header hunt.
// Throughput: one byte per cycle unless o_evt stalls. The byte is consumed in
// the cycle it is accepted and its event shows on o_evt in the cycle after,
// out of a single output register; the parser state update is the only loop.
// Stall: while o_evt holds an untaken event, i_rx stays ready only if the
// sink takes that event in the same cycle, so no event is lost or repeated.
// Reset (synchronous, active low): header hunt, no pending event, header
// bytes back to FE and FC.
module param_frame_parser_top #(
    parameter int NAME_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfp_in_if.sink      i_rx,
    pfp_cfg_if.sink     i_cfg,
    pfp_out_if.source   o_evt
);

    logic [pfp_pkg::BYTE_W-1:0] r_hdr_first;
    logic [pfp_pkg::BYTE_W-1:0] r_hdr_second;
    logic                       r_out_valid;
    pfp_pkg::t_result           r_out;

    logic                       rx_ready;
    logic                       step;
    logic                       res_valid;
    pfp_pkg::t_result           res;

    // accept a byte whenever the output slot is free or being drained
    assign rx_ready   = !r_out_valid || o_evt.ready;
    assign step       = i_rx.valid && rx_ready;
    assign i_rx.ready = rx_ready;
    assign i_cfg.ready = 1'b1;

    // header byte registers; writes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= pfp_pkg::HEADER_FIRST_RST;
            r_hdr_second <= pfp_pkg::HEADER_SECOND_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pfp_pkg::REG_HEADER_FIRST:  r_hdr_first  <= i_cfg.data;
                pfp_pkg::REG_HEADER_SECOND: r_hdr_second <= i_cfg.data;
                default: ;
            endcase
        end
    end

    pfp_core #(
        .NAME_BYTES (NAME_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (i_rx.rx_byte),
        .i_hdr_first  (r_hdr_first),
        .i_hdr_second (r_hdr_second),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // output register: load on a new event, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rx_ready) begin
            r_out_valid <= step && res_valid;
        end
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_kind   = r_out.event_kind;
    assign o_evt.record_name  = r_out.record_name;
    assign o_evt.record_value = r_out.record_value;
    assign o_evt.frame_count  = r_out.frame_count;
    assign o_evt.last_record  = r_out.last_record;

endmodule
